// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files; the core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define KPI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Next-cycle implication built on the macro above.
`define KPI_ASSERT_NEXT(lbl, ante, cons, msg) \
   `KPI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/kpi_pkg.sv =====
// Types, constants and helpers of the kinematic pose integrator.
package kpi_pkg;

   localparam int CORDIC_ITERS = 24;
   localparam int CNT_W = ($clog2(CORDIC_ITERS) > 5) ? $clog2(CORDIC_ITERS) : 5;
   localparam int CSR_AW = 5;

   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [32:0] RECIP3      = 33'sh0AAAAAAAB;
   localparam logic signed [32:0] HALF_Q30    = 33'sd536870912;
   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

   typedef struct packed {
      logic               first_sample;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic signed [31:0] jerk_x;
      logic signed [31:0] jerk_y;
      logic signed [31:0] jerk_z;
      logic signed [31:0] yaw_rate;
      logic signed [31:0] yaw_accel;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_z;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_RED, ST_CORD
   } state_type;

   // multiplier micro-ops, issued in this order
   typedef enum logic [4:0] {
      U_C2, U_T, U_C3,
      U_VX, U_AX, U_JX, U_VY, U_AY, U_JY, U_VZ, U_AZ, U_JZ,
      U_YR, U_YA,
      U_DD, U_Q, U_SZ,
      U_QW0, U_QW1, U_QZ0, U_QZ1
   } uop_type;

   typedef enum logic [2:0] {
      REG_START_X, REG_START_Y, REG_START_Z, REG_START_QW, REG_START_QZ,
      REG_ENABLE, REG_STEP_PERIOD
   } reg_type;

   function automatic logic [29:0] atan_lut(input logic [4:0] k);
      logic [29:0] v;
      unique case (k)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd31: v = 30'd0;
         default: v = 30'd1 << (5'd30 - k);
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat_pos(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -36'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat_q(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd1073741824) r = ONE_Q30;
      else if (v < -36'sd1073741824) r = -ONE_Q30;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hw/rtl/kinematic_pose_integrator_core.sv =====
// Top level: dead-reckoning integrator of position and yaw quaternion.
//
// Input channel req_*: one velocity-profile item per handshake (valid high,
// stall low at a rising edge). Result channel rsp_*: one pose item per input
// item, the pose before that item's step. csr_*: APB-style register port.
// The result is registered as the input item is taken; the integration
// then runs on one shared 33x33 multiplier under a micro-op sequencer,
// each product passing through ST_MUL and then ST_ACC. With integration
// on, the next item waits for the sequencer; when the yaw step is not on
// the small-angle path it also runs the CORDIC (a 16-step modulo-2pi
// reduction, fold, then one rotation per cycle). With integration off,
// the next item can be taken as soon as the result register is free.
// req_stall is high while the sequencer works or while a result waits on a
// stalled receiver; a stalled result holds. Reset clears control, loads the
// register defaults and sets the pose to the default start pose.
module kinematic_pose_integrator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kpi_pkg::req_type              req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kpi_pkg::rsp_type              rsp_item,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kpi_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import kpi_pkg::*;
   `include "assert_macros.svh"

   // configuration
   logic signed [31:0] start_x_ff, start_y_ff, start_z_ff, start_qw_ff, start_qz_ff;
   logic               en_ff;
   logic [15:0]        dt_ff;
   reg_type            csr_idx;
   logic               csr_wr;

   // control
   state_type          state_ff, state_in;
   uop_type            uop_ff, uop_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   req_type            req_ff;
   logic               req_accept;
   logic               load;

   // pose state
   logic signed [31:0] cur_x_ff, cur_y_ff, cur_z_ff, cur_qw_ff, cur_qz_ff;

   // datapath
   logic [31:0]        c2_ff, c3_ff, q_ff;
   logic signed [65:0] prod_ff, acc_ff;
   logic signed [33:0] dyaw_ff;
   logic [26:0]        d2_ff;
   logic signed [31:0] cw_ff, sz_ff, nqw_ff;
   logic [48:0]        rem_ff;
   logic               hneg_ff, neg_ff;
   logic signed [34:0] r_ff;
   logic signed [33:0] x_ff, y_ff;

   logic signed [32:0] opa, opb, dval, hq;
   logic signed [65:0] term, sum_k, ksum, rq_m, rq_p;
   logic signed [33:0] ks;
   logic signed [31:0] cur_sel;
   logic signed [35:0] newp;
   logic               small_yaw;
   logic signed [46:0] hval;
   logic [46:0]        hmag;
   logic [48:0]        sub;
   logic [4:0]         k;
   logic signed [34:0] atan_v;

   assign csr_idx    = reg_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_START_X:     csr_prdata = start_x_ff;
         REG_START_Y:     csr_prdata = start_y_ff;
         REG_START_Z:     csr_prdata = start_z_ff;
         REG_START_QW:    csr_prdata = start_qw_ff;
         REG_START_QZ:    csr_prdata = start_qz_ff;
         REG_ENABLE:      csr_prdata = {31'd0, en_ff};
         REG_STEP_PERIOD: csr_prdata = {16'd0, dt_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0; start_y_ff <= '0; start_z_ff <= '0;
         start_qw_ff <= ONE_Q30; start_qz_ff <= '0;
         en_ff <= 1'b1; dt_ff <= 16'd66;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_START_X:     start_x_ff  <= csr_pwdata;
            REG_START_Y:     start_y_ff  <= csr_pwdata;
            REG_START_Z:     start_z_ff  <= csr_pwdata;
            REG_START_QW:    start_qw_ff <= csr_pwdata;
            REG_START_QZ:    start_qz_ff <= csr_pwdata;
            REG_ENABLE:      en_ff       <= csr_pwdata[0];
            REG_STEP_PERIOD: dt_ff       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // handshake: one item in flight, result register frees on take
   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;
   assign load       = req_item.first_sample || !en_ff;

   // multiplier operand select
   assign dval = {{3{dyaw_ff[15]}}, dyaw_ff[15:0], 14'd0};
   assign hq   = HALF_Q30 - $signed({1'b0, q_ff});
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (uop_ff)
         U_C2:  begin opa = {17'd0, dt_ff}; opb = {17'd0, dt_ff}; end
         U_T:   begin opa = {17'd0, dt_ff}; opb = {1'b0, c2_ff}; end
         U_C3:  begin opa = {1'b0, c3_ff};  opb = RECIP3; end
         U_VX:  begin opa = {req_ff.vel_x[31], req_ff.vel_x};   opb = {1'b0, dt_ff, 16'd0}; end
         U_AX:  begin opa = {req_ff.acc_x[31], req_ff.acc_x};   opb = {1'b0, c2_ff}; end
         U_JX:  begin opa = {req_ff.jerk_x[31], req_ff.jerk_x}; opb = {1'b0, c3_ff}; end
         U_VY:  begin opa = {req_ff.vel_y[31], req_ff.vel_y};   opb = {1'b0, dt_ff, 16'd0}; end
         U_AY:  begin opa = {req_ff.acc_y[31], req_ff.acc_y};   opb = {1'b0, c2_ff}; end
         U_JY:  begin opa = {req_ff.jerk_y[31], req_ff.jerk_y}; opb = {1'b0, c3_ff}; end
         U_VZ:  begin opa = {req_ff.vel_z[31], req_ff.vel_z};   opb = {1'b0, dt_ff, 16'd0}; end
         U_AZ:  begin opa = {req_ff.acc_z[31], req_ff.acc_z};   opb = {1'b0, c2_ff}; end
         U_JZ:  begin opa = {req_ff.jerk_z[31], req_ff.jerk_z}; opb = {1'b0, c3_ff}; end
         U_YR:  begin
            opa = {req_ff.yaw_rate[31], req_ff.yaw_rate}; opb = {1'b0, dt_ff, 16'd0};
         end
         U_YA:  begin
            opa = {req_ff.yaw_accel[31], req_ff.yaw_accel}; opb = {1'b0, c2_ff};
         end
         U_DD:  begin opa = dval; opb = dval; end
         U_Q:   begin opa = {10'd0, d2_ff[26:4]}; opb = RECIP3; end
         U_SZ:  begin opa = hq; opb = dval; end
         U_QW0: begin opa = {cw_ff[31], cw_ff}; opb = {cur_qw_ff[31], cur_qw_ff}; end
         U_QW1: begin opa = {sz_ff[31], sz_ff}; opb = {cur_qz_ff[31], cur_qz_ff}; end
         U_QZ0: begin opa = {cw_ff[31], cw_ff}; opb = {cur_qz_ff[31], cur_qz_ff}; end
         U_QZ1: begin opa = {sz_ff[31], sz_ff}; opb = {cur_qw_ff[31], cur_qw_ff}; end
         default: ;
      endcase
   end

   // term sums: each product floored to 2^-32, sum rounded half up to Q16.16
   assign term  = prod_ff >>> 16;
   assign sum_k = acc_ff + term;
   assign ksum  = (sum_k + 66'sd32768) >>> 16;
   assign ks    = ksum[33:0];
   assign rq_m  = (acc_ff - prod_ff + 66'sd536870912) >>> 30;
   assign rq_p  = (acc_ff + prod_ff + 66'sd536870912) >>> 30;

   always_comb begin
      unique case (uop_ff)
         U_JX:    cur_sel = cur_x_ff;
         U_JY:    cur_sel = cur_y_ff;
         default: cur_sel = cur_z_ff;
      endcase
   end
   assign newp  = {{4{cur_sel[31]}}, cur_sel} + {{2{ks[33]}}, ks};
   // path choice is made on the yaw step as it is being summed
   assign small_yaw = (ks > -34'sd16384) && (ks < 34'sd16384);

   // range reduction and CORDIC helpers
   assign hval   = {dyaw_ff, 13'd0};
   assign hmag   = hval[46] ? 47'(-hval) : 47'(hval);
   assign sub    = {14'd0, TWO_PI_Q30} << (4'd15 - cnt_ff[3:0]);
   assign k      = cnt_ff[4:0];
   assign atan_v = {5'd0, atan_lut(k)};

   // sequencer
   always_comb begin
      state_in = state_ff;
      uop_in   = uop_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && en_ff) begin
               state_in = ST_MUL;
               uop_in   = U_C2;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            priority if (uop_ff == U_QZ1) begin
               state_in = ST_IDLE;
            end else if (uop_ff == U_YA && !small_yaw) begin
               state_in = ST_RED;
               cnt_in   = '0;
            end else if (uop_ff == U_SZ) begin
               state_in = ST_MUL;
               uop_in   = U_QW0;
            end else begin
               state_in = ST_MUL;
               uop_in   = uop_type'(uop_ff + 5'd1);
            end
         end
         ST_RED: begin
            if (cnt_ff == CNT_W'(18)) begin
               state_in = ST_CORD;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CORD: begin
            if (cnt_ff == CNT_W'(CORDIC_ITERS - 1)) begin
               state_in = ST_MUL;
               uop_in   = U_QW0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         uop_ff       <= U_C2;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
         cnt_ff   <= cnt_in;
         if (req_accept) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // pose state: reset loads the default start pose
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0; cur_y_ff <= '0; cur_z_ff <= '0;
         cur_qw_ff <= ONE_Q30; cur_qz_ff <= '0;
      end else if (req_accept && load) begin
         cur_x_ff <= start_x_ff; cur_y_ff <= start_y_ff; cur_z_ff <= start_z_ff;
         cur_qw_ff <= start_qw_ff; cur_qz_ff <= start_qz_ff;
      end else if (state_ff == ST_ACC) begin
         unique case (uop_ff)
            U_JX:  cur_x_ff <= sat_pos(newp);
            U_JY:  cur_y_ff <= sat_pos(newp);
            U_JZ:  cur_z_ff <= sat_pos(newp);
            U_QZ1: begin
               cur_qw_ff <= nqw_ff;
               cur_qz_ff <= sat_q(rq_p[35:0]);
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_item;
         rsp_ff.pos_x  <= load ? start_x_ff  : cur_x_ff;
         rsp_ff.pos_y  <= load ? start_y_ff  : cur_y_ff;
         rsp_ff.pos_z  <= load ? start_z_ff  : cur_z_ff;
         rsp_ff.quat_w <= load ? start_qw_ff : cur_qw_ff;
         rsp_ff.quat_z <= load ? start_qz_ff : cur_qz_ff;
      end
      if (state_ff == ST_MUL) prod_ff <= opa * opb;
      if (state_ff == ST_ACC) begin
         unique case (uop_ff)
            U_C2:  c2_ff <= prod_ff[32:1];
            U_T:   c3_ff <= prod_ff[47:16];
            U_C3:  c3_ff <= prod_ff[64:33];
            U_VX, U_VY, U_VZ, U_YR: acc_ff <= term;
            U_AX, U_AY, U_AZ:       acc_ff <= sum_k;
            U_YA:  begin
               dyaw_ff <= ks;
               rem_ff  <= {2'd0, (ks[33] ? 47'(-$signed({ks, 13'd0}))
                                         : 47'({ks, 13'd0}))};
               hneg_ff <= ks[33];
            end
            U_DD:  d2_ff <= 27'(((prod_ff + 66'sd536870912) >>> 30));
            U_Q:   begin
               q_ff  <= prod_ff[64:33];
               cw_ff <= ONE_Q30 - $signed({8'd0, d2_ff[26:3]});
            end
            U_SZ:  sz_ff <= 32'(((prod_ff + 66'sd536870912) >>> 30));
            U_QW0, U_QZ0: acc_ff <= prod_ff;
            U_QW1: nqw_ff <= sat_q(rq_m[35:0]);
            default: ;
         endcase
      end
      if (state_ff == ST_RED) begin
         // steps 0..15: restoring reduction of |h| modulo 2*pi
         if (cnt_ff < CNT_W'(16)) begin
            if (rem_ff >= sub) rem_ff <= rem_ff - sub;
         end else if (cnt_ff == CNT_W'(16)) begin
            r_ff <= hneg_ff ? -$signed(rem_ff[34:0]) : $signed(rem_ff[34:0]);
         end else if (cnt_ff == CNT_W'(17)) begin
            if (r_ff > PI_Q30) r_ff <= r_ff - TWO_PI_Q30;
            else if (r_ff < -PI_Q30) r_ff <= r_ff + TWO_PI_Q30;
         end else begin
            // fold into [-pi/2, pi/2], flip the result sign
            x_ff   <= GAIN_Q30;
            y_ff   <= '0;
            neg_ff <= (r_ff > HALF_PI_Q30) || (r_ff < -HALF_PI_Q30);
            if (r_ff > HALF_PI_Q30) r_ff <= r_ff - PI_Q30;
            else if (r_ff < -HALF_PI_Q30) r_ff <= r_ff + PI_Q30;
         end
      end
      if (state_ff == ST_CORD) begin
         if (!r_ff[34]) begin
            x_ff <= x_ff - (y_ff >>> k);
            y_ff <= y_ff + (x_ff >>> k);
            r_ff <= r_ff - atan_v;
         end else begin
            x_ff <= x_ff + (y_ff >>> k);
            y_ff <= y_ff - (x_ff >>> k);
            r_ff <= r_ff + atan_v;
         end
         if (cnt_ff == CNT_W'(CORDIC_ITERS - 1)) begin
            cw_ff <= neg_ff ? 32'(-(x_ff - (r_ff[34] ? -(y_ff >>> k) : (y_ff >>> k))))
                            : 32'(x_ff - (r_ff[34] ? -(y_ff >>> k) : (y_ff >>> k)));
            sz_ff <= neg_ff ? 32'(-(y_ff + (r_ff[34] ? -(x_ff >>> k) : (x_ff >>> k))))
                            : 32'(y_ff + (r_ff[34] ? -(x_ff >>> k) : (x_ff >>> k)));
         end
      end
   end

   // hmag mirrors the reduction input for the red_mag_match check below
   `KPI_ASSERT(busy_stalls, (state_ff != ST_IDLE) |-> req_stall, "input taken while busy")
   `KPI_ASSERT_NEXT(accept_gives_rsp, req_accept, rsp_valid_ff, "accepted item gave no result")
   `KPI_ASSERT_NEXT(hold_when_off, req_accept && !en_ff, state_ff == ST_IDLE,
                    "sequencer ran with integration off")
   `KPI_ASSERT(red_mag_match, (state_ff == ST_RED && cnt_ff == '0) |-> (rem_ff[46:0] == hmag),
               "reduction input mismatch")

endmodule
